// ----- design/ccfd_pkg.sv -----
// Shared types and constants for the sync/length/CRC frame deframer.
// Used by ccfd_ctrl, ccfd_dp and crc_checked_frame_deframer_core.
// No dependencies.
package ccfd_pkg;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_CONT  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] ST_WAIT    = 2'd0;
  localparam logic [1:0] ST_FRAME   = 2'd1;
  localparam logic [1:0] ST_RDATA   = 2'd2;
  localparam logic [1:0] ST_RBEYOND = 2'd3;

  localparam logic [15:0] SYNC_RESET = 16'h444D;  // "MD"
  localparam logic [15:0] MIN_FRAME  = 16'd8;
  localparam logic [15:0] HDR_BYTES  = 16'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_SCAN, S_CHECK, S_HDR, S_EVAL, S_CRC, S_VERIFY,
    S_COPY, S_ACCEPT, S_FINISH, S_RD, S_RD_DONE, S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    W_HDR, W_CRC, W_COPY
  } walk_t;

  typedef struct packed {
    logic  capture;
    logic  push;
    logic  scan_init;
    logic  walk_init;
    logic  walk_step;
    walk_t walk_mode;
    logic  adv;
    logic  accept;
    logic  finish;
    logic  rd_done;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       rem_ge8;
    logic       hdr_ok;
    logic       fits;
    logic       walk_last;
    logic       crc_ok;
  } sts_t;

endpackage

// ----- design/ccfd_ctrl.sv -----
// Controller state machine of the frame deframer.
// Depends on ccfd_pkg; drives ccfd_dp through ccfd_pkg::cmd_t.
module ccfd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_stall,
  input  ccfd_pkg::sts_t  sts,
  output ccfd_pkg::cmd_t  cmd,
  output logic            in_stall,
  output logic            out_valid
);

  ccfd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccfd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccfd_pkg::S_IDLE: begin
        if (in_valid) begin
          case (sts.mode)
            ccfd_pkg::MODE_PUSH: state_nxt = ccfd_pkg::S_PUSH;
            ccfd_pkg::MODE_CONT: state_nxt = ccfd_pkg::S_SCAN;
            ccfd_pkg::MODE_READ: state_nxt = ccfd_pkg::S_RD;
            default:             state_nxt = ccfd_pkg::S_RESULT;
          endcase
        end
      end
      ccfd_pkg::S_PUSH:  state_nxt = ccfd_pkg::S_SCAN;
      ccfd_pkg::S_SCAN:  state_nxt = ccfd_pkg::S_CHECK;
      ccfd_pkg::S_CHECK: state_nxt = sts.rem_ge8 ? ccfd_pkg::S_HDR : ccfd_pkg::S_FINISH;
      ccfd_pkg::S_HDR: begin
        if (sts.walk_last) state_nxt = ccfd_pkg::S_EVAL;
      end
      ccfd_pkg::S_EVAL: begin
        if (!sts.hdr_ok) state_nxt = ccfd_pkg::S_CHECK;
        else if (!sts.fits) state_nxt = ccfd_pkg::S_FINISH;
        else state_nxt = ccfd_pkg::S_CRC;
      end
      ccfd_pkg::S_CRC: begin
        if (sts.walk_last) state_nxt = ccfd_pkg::S_VERIFY;
      end
      ccfd_pkg::S_VERIFY: state_nxt = sts.crc_ok ? ccfd_pkg::S_COPY : ccfd_pkg::S_CHECK;
      ccfd_pkg::S_COPY: begin
        if (sts.walk_last) state_nxt = ccfd_pkg::S_ACCEPT;
      end
      ccfd_pkg::S_ACCEPT:  state_nxt = ccfd_pkg::S_FINISH;
      ccfd_pkg::S_FINISH:  state_nxt = ccfd_pkg::S_RESULT;
      ccfd_pkg::S_RD:      state_nxt = ccfd_pkg::S_RD_DONE;
      ccfd_pkg::S_RD_DONE: state_nxt = ccfd_pkg::S_RESULT;
      ccfd_pkg::S_RESULT: begin
        if (!out_stall) state_nxt = ccfd_pkg::S_IDLE;
      end
      default: state_nxt = ccfd_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.walk_mode = ccfd_pkg::W_HDR;
    in_stall  = (state_r != ccfd_pkg::S_IDLE);
    out_valid = (state_r == ccfd_pkg::S_RESULT);
    case (state_r)
      ccfd_pkg::S_IDLE:   cmd.capture   = in_valid;
      ccfd_pkg::S_PUSH:   cmd.push      = 1'b1;
      ccfd_pkg::S_SCAN:   cmd.scan_init = 1'b1;
      ccfd_pkg::S_CHECK:  cmd.walk_init = sts.rem_ge8;
      ccfd_pkg::S_HDR: begin
        cmd.walk_step = 1'b1;
        cmd.walk_mode = ccfd_pkg::W_HDR;
      end
      ccfd_pkg::S_EVAL: begin
        cmd.adv       = !sts.hdr_ok;
        cmd.walk_init = sts.hdr_ok && sts.fits;
      end
      ccfd_pkg::S_CRC: begin
        cmd.walk_step = 1'b1;
        cmd.walk_mode = ccfd_pkg::W_CRC;
      end
      ccfd_pkg::S_VERIFY: begin
        cmd.adv       = !sts.crc_ok;
        cmd.walk_init = sts.crc_ok;
      end
      ccfd_pkg::S_COPY: begin
        cmd.walk_step = 1'b1;
        cmd.walk_mode = ccfd_pkg::W_COPY;
      end
      ccfd_pkg::S_ACCEPT:  cmd.accept  = 1'b1;
      ccfd_pkg::S_FINISH:  cmd.finish  = 1'b1;
      ccfd_pkg::S_RD_DONE: cmd.rd_done = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- design/ccfd_dp.sv -----
// Datapath of the frame deframer: window ring, payload store, CRC unit.
// Depends on ccfd_pkg; commanded by ccfd_ctrl.
module ccfd_dp #(
  parameter int MAX_FRAME = 2048
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ccfd_pkg::cmd_t  cmd,
  output ccfd_pkg::sts_t  sts,
  input  logic [1:0]      in_mode,
  input  logic [7:0]      in_data_byte,
  input  logic [10:0]     in_read_index,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_sync_word,
  output logic [1:0]      out_status,
  output logic [15:0]     out_command_type,
  output logic [10:0]     out_payload_length,
  output logic [7:0]      out_read_data,
  output logic            out_more_to_scan,
  output logic [11:0]     out_bytes_held
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int IW = (AW > 11) ? AW : 11;
  localparam int BW = (CW > 12) ? CW : 12;
  localparam logic [AW-1:0] PTR_LAST = AW'(MAX_FRAME - 1);

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
    end
    return x;
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + AW'(1);
  endfunction

  logic [7:0]    win_mem [MAX_FRAME];
  logic [7:0]    pl_mem  [MAX_FRAME];
  logic [7:0]    win_q, pl_q;

  logic [15:0]   sync_r;
  logic [AW-1:0] head_r, tail_r, sp_r, rp_r;
  logic [CW-1:0] cnt_r, rem_r;
  logic [15:0]   c_r;
  logic [31:0]   crc_r;
  logic [7:0]    hdr_r [6];
  logic [15:0]   chk_r;
  logic          acc_r, pend_r, apend_r;
  logic [15:0]   last_cmd_r, last_len_r;
  logic [1:0]    status_r, mode_r;
  logic [7:0]    rdata_r, data_r;
  logic [10:0]   ridx_r;

  logic [15:0]   len, bidx, target, rem_left;
  logic [16:0]   sp_sum, sp_wrap;
  logic          full, in_range, pl_we;
  logic [AW-1:0] pl_wa, pl_ra;
  logic [IW-1:0] ridx_ext;
  logic [BW-1:0] held_ext;

  assign len      = {hdr_r[3], hdr_r[2]};
  assign bidx     = c_r - 16'd1;
  assign full     = (cnt_r == CW'(MAX_FRAME));
  assign rem_left = 16'(rem_r) - len;
  assign sp_sum   = 17'(sp_r) + 17'(len);
  assign sp_wrap  = (sp_sum >= 17'(MAX_FRAME)) ? sp_sum - 17'(MAX_FRAME) : sp_sum;
  assign in_range = (16'(ridx_r) < last_len_r) && (17'(ridx_r) < 17'(MAX_FRAME));
  assign ridx_ext = IW'(ridx_r);
  assign pl_ra    = ridx_ext[AW-1:0];
  assign pl_we    = cmd.walk_step && (cmd.walk_mode == ccfd_pkg::W_COPY) && (c_r >= 16'd7);
  assign pl_wa    = AW'(c_r - 16'd7);

  always_comb begin
    case (cmd.walk_mode)
      ccfd_pkg::W_HDR:  target = ccfd_pkg::HDR_BYTES;
      ccfd_pkg::W_CRC:  target = len;
      ccfd_pkg::W_COPY: target = len - 16'd2;
      default:          target = ccfd_pkg::HDR_BYTES;
    endcase
  end

  assign sts.mode      = mode_r;
  assign sts.rem_ge8   = (16'(rem_r) >= ccfd_pkg::MIN_FRAME);
  assign sts.hdr_ok    = ({hdr_r[1], hdr_r[0]} == sync_r) && (len >= ccfd_pkg::MIN_FRAME)
                         && (17'(len) <= 17'(MAX_FRAME));
  assign sts.fits      = (17'(len) <= 17'(rem_r));
  assign sts.walk_last = (c_r == target);
  assign sts.crc_ok    = ((~crc_r[15:0]) == chk_r);

  // memories
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      win_mem[tail_r] <= data_r;
    end
    win_q <= win_mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (pl_we) begin
      pl_mem[pl_wa] <= win_q;
    end
    pl_q <= pl_mem[pl_ra];
  end

  // control / architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r     <= ccfd_pkg::SYNC_RESET;
      head_r     <= '0;
      tail_r     <= '0;
      cnt_r      <= '0;
      pend_r     <= 1'b0;
      last_cmd_r <= '0;
      last_len_r <= '0;
    end else begin
      if (cfg_we) sync_r <= cfg_sync_word;
      if (cmd.push) begin
        tail_r <= ptr_inc(tail_r);
        if (full) head_r <= ptr_inc(head_r);
        else cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.accept) begin
        last_cmd_r <= {hdr_r[5], hdr_r[4]};
        last_len_r <= len - ccfd_pkg::MIN_FRAME;
      end
      if (cmd.finish) begin
        head_r <= sp_r;
        cnt_r  <= rem_r;
        pend_r <= acc_r && apend_r;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_mode;
      data_r   <= in_data_byte;
      ridx_r   <= in_read_index;
      status_r <= ccfd_pkg::ST_WAIT;
      rdata_r  <= '0;
    end
    if (cmd.scan_init) begin
      sp_r  <= head_r;
      rem_r <= cnt_r;
      acc_r <= 1'b0;
    end
    if (cmd.walk_init) begin
      rp_r  <= sp_r;
      c_r   <= '0;
      crc_r <= 32'hFFFFFFFF;
    end
    if (cmd.walk_step) begin
      rp_r <= ptr_inc(rp_r);
      c_r  <= c_r + 16'd1;
      if (c_r != 16'd0) begin
        case (cmd.walk_mode)
          ccfd_pkg::W_HDR: hdr_r[bidx[2:0]] <= win_q;
          ccfd_pkg::W_CRC: begin
            if (bidx < len - 16'd2) crc_r <= crc_byte(crc_r, win_q);
            else if (bidx == len - 16'd2) chk_r[7:0] <= win_q;
            else chk_r[15:8] <= win_q;
          end
          default: ;
        endcase
      end
    end
    if (cmd.adv) begin
      sp_r  <= ptr_inc(sp_r);
      rem_r <= rem_r - CW'(1);
    end
    if (cmd.accept) begin
      sp_r    <= sp_wrap[AW-1:0];
      rem_r   <= CW'(rem_left);
      acc_r   <= 1'b1;
      apend_r <= (rem_left >= ccfd_pkg::MIN_FRAME);
    end
    if (cmd.finish) begin
      status_r <= acc_r ? ccfd_pkg::ST_FRAME : ccfd_pkg::ST_WAIT;
    end
    if (cmd.rd_done) begin
      status_r <= in_range ? ccfd_pkg::ST_RDATA : ccfd_pkg::ST_RBEYOND;
      rdata_r  <= in_range ? pl_q : 8'd0;
    end
  end

  assign held_ext           = BW'(cnt_r);
  assign out_status         = status_r;
  assign out_command_type   = last_cmd_r;
  assign out_payload_length = last_len_r[10:0];
  assign out_read_data      = rdata_r;
  assign out_more_to_scan   = pend_r;
  assign out_bytes_held     = held_ext[11:0];

endmodule

// ----- design/crc_checked_frame_deframer_core.sv -----
// Sync/length/CRC frame deframer, top level.
// Depends on ccfd_pkg, ccfd_ctrl and ccfd_dp.
//
// Bytes pushed in are kept in a ring window of MAX_FRAME bytes. Each push or
// continue item scans the window from its head for a frame: two sync bytes
// (cfg sync word, first byte in bits 7..0), a little-endian total length L
// (8..MAX_FRAME), a command word, L-8 payload bytes and a 16-bit check equal
// to the low half of the reflected CRC-32 over the first L-2 bytes. A bad
// candidate drops one byte and the scan goes on; an incomplete frame stops
// the scan; a good frame is accepted, its payload copied to the read store,
// and the scan stops. Read items return one payload byte. One result per
// item; one item is in flight at a time (in_stall is high from acceptance
// until the result transfer). Each candidate offset inspected costs a
// header fetch over the single window read port; a candidate whose header
// is good and fits is walked again for its CRC, and an accepted one once
// more to copy its payload. The window is walked one byte per cycle
// through its one read port, so the scan length sets the rate. The cfg
// port is always ready; write it only when idle. No clearing pass after
// reset.
module crc_checked_frame_deframer_core #(
  parameter int MAX_FRAME = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic [10:0] in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_command_type,
  output logic [10:0] out_payload_length,
  output logic [7:0]  out_read_data,
  output logic        out_more_to_scan,
  output logic [11:0] out_bytes_held,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_sync_word
);

  ccfd_pkg::cmd_t cmd;
  ccfd_pkg::sts_t sts;
  logic           mode_sel_valid;

  assign cfg_ready = 1'b1;

  // mode goes to the controller straight from the port while idle
  ccfd_pkg::sts_t sts_ctrl;
  always_comb begin
    sts_ctrl      = sts;
    sts_ctrl.mode = in_stall ? sts.mode : in_mode;
  end
  assign mode_sel_valid = in_valid;

  ccfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mode_sel_valid),
    .out_stall (out_stall),
    .sts       (sts_ctrl),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  ccfd_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_mode),
    .in_data_byte       (in_data_byte),
    .in_read_index      (in_read_index),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_sync_word      (cfg_sync_word),
    .out_status         (out_status),
    .out_command_type   (out_command_type),
    .out_payload_length (out_payload_length),
    .out_read_data      (out_read_data),
    .out_more_to_scan   (out_more_to_scan),
    .out_bytes_held     (out_bytes_held)
  );

endmodule
